// ===== src/v3n_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants of the vector length and normalize unit.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned TOL_BITS      = 16;
  localparam int unsigned OP_BITS       = 3;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd7;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_LENGTH  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_NORM    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SETLEN  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_COMPARE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DIVIDE  = 3'd4;

  // how a lane forms its divide
  typedef enum logic [1:0] {
    LANE_PASS = 2'd0,
    LANE_NORM = 2'd1,
    LANE_SCALE = 2'd2,
    LANE_DIV  = 2'd3
  } lane_mode_t;

endpackage
`default_nettype wire

// ===== src/v3n_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_in_if / v3n_out_if
// Valid/ready channels that carry one input word and one result word.
// ----------------------------------------------------------------------------
interface v3n_in_if #(parameter int unsigned W = 32) ();
  logic                         valid;
  logic                         ready;
  logic [v3n_pkg::OP_BITS-1:0]  operation;
  logic signed [W-1:0]          vec_x;
  logic signed [W-1:0]          vec_y;
  logic signed [W-1:0]          vec_z;
  logic signed [W-1:0]          other_x;
  logic signed [W-1:0]          other_y;
  logic signed [W-1:0]          other_z;
  logic signed [W-1:0]          scalar;
  modport source (output valid, operation, vec_x, vec_y, vec_z, other_x, other_y,
                  other_z, scalar, input ready);
  modport sink (input valid, operation, vec_x, vec_y, vec_z, other_x, other_y,
                other_z, scalar, output ready);
endinterface

interface v3n_out_if #(parameter int unsigned W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_x;
  logic signed [W-1:0] res_y;
  logic signed [W-1:0] res_z;
  logic [W-2:0]        magnitude;
  logic                is_equal;
  logic                overflow;
  modport source (output valid, res_x, res_y, res_z, magnitude, is_equal, overflow,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, magnitude, is_equal, overflow,
                output ready);
endinterface
`default_nettype wire

// ===== src/vector3_length_normalize_unit_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_length_normalize_unit_top
// Length, normalize, rescale, compare and divide for a signed 3D vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one word accepted per clock while the output register is
// free or being taken (results in Q16.16 with the default parameters).
// Squares and compare are registered at the accepting edge, then come the
// square root stages (load, one root bit a stage, rounding), a register that
// forms the lane operands, the three lane dividers (load, one quotient bit a
// stage, rounding, saturation) and the output register. The pipeline advances
// whenever the output register is free or being taken, so stalls only come
// from the result side.
module vector3_length_normalize_unit_top #(
  parameter int unsigned WORD_BITS = v3n_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [v3n_pkg::TOL_BITS-1:0]  cfg_wdata,
  v3n_in_if.sink                             in_ch,
  v3n_out_if.source                          out_ch
);
  import v3n_pkg::*;

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned ROOTB = W + 1;
  localparam int unsigned NUMB  = 2 * W + 1 + FRAC_BITS;
  localparam int unsigned DENB  = W + 1;
  localparam int unsigned SQLAT = ROOTB + 2;
  localparam int unsigned DVLAT = NUMB + 3;
  localparam int unsigned LAT   = 1 + SQLAT + 1 + DVLAT;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [W-1:0] vx, vy, vz;
    logic [W-1:0] ms;
    logic ns;
    logic eq;
  } side_t;

  // pipeline moves when the output register can take a word
  logic en;
  logic [LAT-1:0] vld;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // tolerance register
  logic [TOL_BITS-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst) tol <= TOL_RESET;
    else if (cfg_we) tol <= cfg_wdata;
  end

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  // stage 0: magnitudes, squares, compare
  logic [2*W-1:0] sq0, sq1, sq2;
  side_t s0;
  logic [W-1:0] mv [3];
  logic [W-1:0] vi [3];
  logic [W-1:0] oi [3];
  logic [2:0]   in_tol;
  assign vi[0] = in_ch.vec_x; assign vi[1] = in_ch.vec_y; assign vi[2] = in_ch.vec_z;
  assign oi[0] = in_ch.other_x; assign oi[1] = in_ch.other_y; assign oi[2] = in_ch.other_z;
  for (genvar i = 0; i < 3; i++) begin : g_cmp
    logic signed [W:0] d;
    logic [W:0] ad;
    assign mv[i] = mag_of(vi[i]);
    assign d  = $signed({oi[i][W-1], oi[i]}) - $signed({vi[i][W-1], vi[i]});
    assign ad = d[W] ? ((W+1)'(0) - d) : d;
    assign in_tol[i] = ad <= (W+1)'(tol);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq0 <= mv[0] * mv[0];
      sq1 <= mv[1] * mv[1];
      sq2 <= mv[2] * mv[2];
      s0  <= '{op: in_ch.operation, vx: in_ch.vec_x, vy: in_ch.vec_y, vz: in_ch.vec_z,
               ms: mag_of(in_ch.scalar), ns: in_ch.scalar[W-1], eq: &in_tol};
    end
  end

  // square root of sum of squares
  logic [ROOTB-1:0] len;
  side_t s1;
  v3n_sqrt #(.IN_BITS(2*W+2), .ROOT_BITS(ROOTB), .SIDE_BITS($bits(side_t))) u_sqrt (
    .clk(clk), .en(en),
    .rad({2'b00, sq0} + {2'b00, sq1} + {2'b00, sq2}),
    .side_in(s0), .root(len), .side_out(s1)
  );

  // stage: numerators, denominators per lane
  logic [NUMB-1:0] num [3];
  logic [DENB-1:0] den;
  logic            lneg [3];
  logic [W-1:0]    vreg [3];
  lane_mode_t      mode;
  side_t           s2;
  logic            mag_sat2;
  logic [W-2:0]    mag2;
  logic [W-1:0]    sv [3];
  assign sv[0] = s1.vx; assign sv[1] = s1.vy; assign sv[2] = s1.vz;
  always_ff @(posedge clk) begin
    if (en) begin
      s2       <= s1;
      mag_sat2 <= len > ROOTB'({(W-1){1'b1}});
      mag2     <= (len > ROOTB'({(W-1){1'b1}})) ? {(W-1){1'b1}} : len[W-2:0];
      unique case (s1.op)
        OP_NORM:   mode <= (len == '0) ? LANE_PASS : LANE_NORM;
        OP_SETLEN: mode <= (len == '0) ? LANE_PASS : LANE_SCALE;
        OP_DIVIDE: mode <= LANE_DIV;
        default:   mode <= LANE_PASS;
      endcase
      if (s1.op == OP_DIVIDE) den <= (s1.ms == '0) ? DENB'(1) : DENB'(s1.ms);
      else den <= (len == '0) ? DENB'(1) : len;
      for (int i = 0; i < 3; i++) begin
        vreg[i] <= sv[i];
        if (s1.op == OP_SETLEN) begin
          num[i]  <= NUMB'({{W{1'b0}}, mag_of(sv[i])} * {{W{1'b0}}, s1.ms});
          lneg[i] <= sv[i][W-1] ^ s1.ns;
        end else if (s1.op == OP_DIVIDE) begin
          num[i]  <= NUMB'(mag_of(sv[i])) << FRAC_BITS;
          lneg[i] <= sv[i][W-1] ^ s1.ns;
        end else begin
          num[i]  <= NUMB'(mag_of(sv[i])) << FRAC_BITS;
          lneg[i] <= sv[i][W-1];
        end
      end
    end
  end

  // delay of control words alongside lanes
  typedef struct packed {
    lane_mode_t mode;
    logic [W-1:0] vx, vy, vz;
    logic [W-2:0] mag;
    logic msat, eq, dz;
  } ctl_t;
  ctl_t ctl_q [DVLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_q[0] <= '{mode: mode, vx: vreg[0], vy: vreg[1], vz: vreg[2], mag: mag2,
                    msat: mag_sat2, eq: s2.eq, dz: (s2.ms == '0)};
      for (int k = 1; k < DVLAT; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // three divider lanes
  logic [W-1:0] lw [3];
  logic [2:0]   lsat;
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3n_lane #(.WORD_BITS(W), .NUM_BITS(NUMB), .DEN_BITS(DENB)) u_lane (
      .clk(clk), .en(en), .num(num[i]), .den(den), .neg(lneg[i]),
      .word(lw[i]), .sat(lsat[i])
    );
  end

  // merge lanes into the result word
  ctl_t c;
  logic [W-1:0] cv [3];
  logic [W-1:0] rr [3];
  logic         ovf;
  assign c = ctl_q[DVLAT-1];
  assign cv[0] = c.vx; assign cv[1] = c.vy; assign cv[2] = c.vz;
  always_comb begin
    ovf = c.msat;
    for (int i = 0; i < 3; i++) begin
      rr[i] = cv[i];
      case (c.mode)
        LANE_NORM, LANE_SCALE: begin
          rr[i] = lw[i];
          ovf = ovf | lsat[i];
        end
        LANE_DIV: begin
          if (c.dz) begin
            rr[i] = (cv[i] == '0) ? '0 : (cv[i][W-1] ? (W'(1) << (W-1))
                                                     : ~(W'(1) << (W-1)));
            ovf = 1'b1;
          end else begin
            rr[i] = lw[i];
            ovf = ovf | lsat[i];
          end
        end
        default: rr[i] = cv[i];
      endcase
    end
  end

  // valid pipe and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
      out_ch.valid <= vld[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.res_x     <= rr[0];
      out_ch.res_y     <= rr[1];
      out_ch.res_z     <= rr[2];
      out_ch.magnitude <= c.mag;
      out_ch.is_equal  <= c.eq;
      out_ch.overflow  <= ovf;
    end
  end

`ifndef SYNTH
  // a held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res_x))
    else $error("result changed while stalled");
  // accept only when the pipeline moves
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready out of step with output register");
  // a presented result carries known flags
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !$isunknown({out_ch.overflow, out_ch.is_equal}))
    else $error("result flags unknown");
`endif
endmodule
`default_nettype wire

// ===== src/v3n_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined restoring square root, one result bit per stage, rounded to
// nearest. Carries a side word along with each operand.
// ----------------------------------------------------------------------------
module v3n_sqrt #(
  parameter int unsigned IN_BITS   = 66,
  parameter int unsigned ROOT_BITS = 33,
  parameter int unsigned SIDE_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [IN_BITS-1:0]   rad,
  input  wire logic [SIDE_BITS-1:0] side_in,
  output logic [ROOT_BITS-1:0]      root,
  output logic [SIDE_BITS-1:0]      side_out
);
  localparam int unsigned RB = 2 * ROOT_BITS + 2;

  logic [RB-1:0]        rem_q  [ROOT_BITS+1];
  logic [2*ROOT_BITS-1:0] src_q [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] r_q    [ROOT_BITS+1];
  logic [SIDE_BITS-1:0] side_q [ROOT_BITS+1];

  // stage 0 load
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      src_q[0]  <= (2*ROOT_BITS)'(rad);
      r_q[0]    <= '0;
      side_q[0] <= side_in;
    end
  end

  // one root bit per stage
  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_st
    logic [RB-1:0] cur;
    logic [RB-1:0] trial;
    assign cur   = {rem_q[s][RB-3:0], src_q[s][2*ROOT_BITS-1 -: 2]};
    assign trial = {{(RB-ROOT_BITS-2){1'b0}}, r_q[s], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        src_q[s+1]  <= {src_q[s][2*ROOT_BITS-3:0], 2'b00};
        side_q[s+1] <= side_q[s];
        if (cur >= trial) begin
          rem_q[s+1] <= cur - trial;
          r_q[s+1]   <= {r_q[s][ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= cur;
          r_q[s+1]   <= {r_q[s][ROOT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // round up when remainder exceeds r (s - r^2 > r)
  always_ff @(posedge clk) begin
    if (en) begin
      root     <= r_q[ROOT_BITS] +
                  ROOT_BITS'(rem_q[ROOT_BITS] > {{(RB-ROOT_BITS){1'b0}}, r_q[ROOT_BITS]});
      side_out <= side_q[ROOT_BITS];
    end
  end
endmodule
`default_nettype wire

// ===== src/v3n_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_lane
// One component lane: pipelined restoring divider with rounding and
// saturation to a signed word.
// ----------------------------------------------------------------------------
module v3n_lane #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned NUM_BITS  = 96,
  parameter int unsigned DEN_BITS  = 33
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [NUM_BITS-1:0]  num,
  input  wire logic [DEN_BITS-1:0]  den,
  input  wire logic                 neg,
  output logic [WORD_BITS-1:0]      word,
  output logic                      sat
);
  localparam int unsigned RB = DEN_BITS + 1;

  logic [RB-1:0]       rem_q [NUM_BITS+1];
  logic [NUM_BITS-1:0] n_q   [NUM_BITS+1];
  logic [NUM_BITS-1:0] q_q   [NUM_BITS+1];
  logic [DEN_BITS-1:0] d_q   [NUM_BITS+1];
  logic                s_q   [NUM_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= '0;
      n_q[0]   <= num;
      q_q[0]   <= '0;
      d_q[0]   <= den;
      s_q[0]   <= neg;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < NUM_BITS; s++) begin : g_st
    logic [RB-1:0] cur;
    assign cur = {rem_q[s][RB-2:0], n_q[s][NUM_BITS-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[s+1] <= {n_q[s][NUM_BITS-2:0], 1'b0};
        d_q[s+1] <= d_q[s];
        s_q[s+1] <= s_q[s];
        if (cur >= {1'b0, d_q[s]}) begin
          rem_q[s+1] <= cur - {1'b0, d_q[s]};
          q_q[s+1]   <= {q_q[s][NUM_BITS-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= cur;
          q_q[s+1]   <= {q_q[s][NUM_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // rounding stage
  logic [NUM_BITS-1:0] qr;
  logic                nr;
  always_ff @(posedge clk) begin
    if (en) begin
      qr <= q_q[NUM_BITS] +
            NUM_BITS'({rem_q[NUM_BITS], 1'b0} >= {2'b00, d_q[NUM_BITS]});
      nr <= s_q[NUM_BITS];
    end
  end

  // saturate and apply sign; a zero quotient is positive
  logic [NUM_BITS-1:0] lim;
  logic                big;
  assign lim = nr ? (NUM_BITS'(1) << (WORD_BITS-1))
                  : ((NUM_BITS'(1) << (WORD_BITS-1)) - NUM_BITS'(1));
  assign big = qr > lim;
  always_ff @(posedge clk) begin
    if (en) begin
      sat  <= big;
      word <= big ? (nr ? WORD_BITS'(0) - lim[WORD_BITS-1:0] : lim[WORD_BITS-1:0])
                  : (nr ? WORD_BITS'(0) - qr[WORD_BITS-1:0] : qr[WORD_BITS-1:0]);
    end
  end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the vector length and normalize unit: every word sent is predicted
// with exact wide integer arithmetic and each result word is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import v3n_pkg::*;

  localparam int unsigned WB = WORD_BITS_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int LATENCY = 4 * WB + FB + 40;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MAXN = 32'h8000_0000;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [31:0] vx, vy, vz, ox, oy, oz, s;
  } vec_word_t;

  typedef struct packed {
    logic [31:0] rx, ry, rz;
    logic [30:0] mag;
    logic        eq;
    logic        ovf;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TOL_BITS-1:0] cfg_wdata = '0;

  v3n_in_if  #(.W(WB)) in_ch ();
  v3n_out_if #(.W(WB)) out_ch ();

  vector3_length_normalize_unit_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [TOL_BITS-1:0] tolerance = TOL_RESET;
  vec_result_t expected_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int rx_wait = 0;
  bit hold_off = 1'b0;
  bit idle_out = 1'b1;

  // rounded square root of a 128-bit sum, exact
  function automatic logic [63:0] round_sqrt(logic [127:0] sq);
    logic [63:0] r;
    logic [63:0] t;
    logic [127:0] rem;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= sq) r = t;
    end
    rem = sq - {64'd0, r} * {64'd0, r};
    if (rem > {64'd0, r}) r = r + 64'd1;
    return r;
  endfunction

  // rounded quotient, halves away from zero
  function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] rem;
    q = num / den;
    rem = num % den;
    if ((rem << 1) >= den) q = q + 128'd1;
    return q;
  endfunction

  // apply sign and saturate
  function automatic logic [31:0] clamp_signed(logic [127:0] m, bit neg, ref bit ovf);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m > lim) begin
      m = lim;
      ovf = 1'b1;
    end
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic vec_result_t predict_vector(vec_word_t w);
    vec_result_t r;
    logic [31:0] v[3], o[3], mv[3], mo[3], outv[3];
    logic [31:0] ms, a, b;
    logic [127:0] sum, q, d;
    logic [63:0] len;
    bit nv[3], no[3], ns, ovf, eq, neg;
    v = '{w.vx, w.vy, w.vz};
    o = '{w.ox, w.oy, w.oz};
    ovf = 0;
    eq = 1;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      nv[i] = v[i][31];
      no[i] = o[i][31];
      mv[i] = nv[i] ? -v[i] : v[i];
      mo[i] = no[i] ? -o[i] : o[i];
      sum += {96'd0, mv[i]} * {96'd0, mv[i]};
    end
    ns = w.s[31];
    ms = ns ? -w.s : w.s;
    len = round_sqrt(sum);
    if (len > 64'h7fff_ffff) begin
      r.mag = 31'h7fff_ffff;
      ovf = 1;
    end else r.mag = len[30:0];
    // per-component tolerance test
    for (int i = 0; i < 3; i++) begin
      a = v[i];
      b = o[i];
      if (nv[i] == no[i]) d = (a >= b) ? a - b : b - a;
      else d = {96'd0, mv[i]} + {96'd0, mo[i]};
      if (d > tolerance) eq = 0;
    end
    for (int i = 0; i < 3; i++) begin
      outv[i] = v[i];
      if (w.op == OP_NORM) begin
        if (len == 0) outv[i] = '0;
        else outv[i] = clamp_signed(round_div({96'd0, mv[i]} << FB, {64'd0, len}),
                                    nv[i], ovf);
      end else if (w.op == OP_SETLEN) begin
        if (len != 0) begin
          q = round_div({96'd0, mv[i]} * {96'd0, ms}, {64'd0, len});
          neg = (nv[i] != ns) && (q != 0);
          outv[i] = clamp_signed(q, neg, ovf);
        end
      end else if (w.op == OP_DIVIDE) begin
        if (ms == 0) begin
          ovf = 1;
          outv[i] = (mv[i] == 0) ? 32'd0 : (nv[i] ? MAXN : MAXP);
        end else begin
          q = round_div({96'd0, mv[i]} << FB, {96'd0, ms});
          neg = (nv[i] != ns) && (q != 0);
          outv[i] = clamp_signed(q, neg, ovf);
        end
      end
    end
    r.rx = outv[0];
    r.ry = outv[1];
    r.rz = outv[2];
    r.eq = eq;
    r.ovf = ovf;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LENGTH;
    in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
    in_ch.other_x = '0; in_ch.other_y = '0; in_ch.other_z = '0;
    in_ch.scalar = '0;
  end

  // send one word after a random gap; valid stays up until the next gap or drain
  task automatic send_word(vec_word_t w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.vec_x <= w.vx; in_ch.vec_y <= w.vy; in_ch.vec_z <= w.vz;
    in_ch.other_x <= w.ox; in_ch.other_y <= w.oy; in_ch.other_z <= w.oz;
    in_ch.scalar <= w.s;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_vector(w));
    words_sent++;
  endtask

  // receiver: random wait per word, or a long hold-off when requested
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      wait_n = idle_out ? $urandom_range(0, 15) : 0;
      rx_wait <= wait_n;
      out_ch.ready <= (wait_n == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else out_ch.ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    vec_result_t got, exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.res_x, out_ch.res_y, out_ch.res_z, out_ch.magnitude,
              out_ch.is_equal, out_ch.overflow};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = val;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MAXP : MAXN;
      1: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
      2: return $urandom_range(0, 131071) - 65536;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_word_t rand_word();
    vec_word_t w;
    w.op = ($urandom_range(0, 9) == 0) ? OP_BITS'($urandom_range(5, 7))
                                       : OP_BITS'($urandom_range(0, 4));
    w.vx = rand_comp(); w.vy = rand_comp(); w.vz = rand_comp();
    // compare partner is often a near copy
    if ($urandom_range(0, 1)) begin
      w.ox = w.vx + $urandom_range(0, 20) - 10;
      w.oy = w.vy + $urandom_range(0, 20) - 10;
      w.oz = w.vz + $urandom_range(0, 20) - 10;
    end else begin
      w.ox = rand_comp(); w.oy = rand_comp(); w.oz = rand_comp();
    end
    w.s = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_comp();
    return w;
  endfunction

  // extremes, every operation, zero vector, zero divisor, negative length
  task automatic test_directed();
    logic [31:0] ext[4];
    vec_word_t w;
    ext = '{MAXP, MAXN, 32'd0, 32'h0001_0000};
    for (int op = 0; op < 8; op++) begin
      w = '{op[2:0], ext[op % 4], ext[(op + 1) % 4], ext[(op + 2) % 4],
            ext[op % 4] + 3, ext[(op + 1) % 4], ext[(op + 3) % 4], 32'hfffe_0000};
      send_word(w);
    end
    send_word('{OP_NORM, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_word('{OP_SETLEN, 32'd0, 32'd0, 32'd0, 32'd7, 32'd0, 32'd0, MAXP});
    send_word('{OP_DIVIDE, 32'd5, 32'hffff_fff0, 32'd0, 32'd5, 32'd0, 32'd0, 32'd0});
    send_word('{OP_DIVIDE, MAXP, MAXN, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
    send_word('{OP_SETLEN, 32'd3, 32'd4, 32'd0, 32'd3, 32'd4, 32'd0, MAXN});
    send_word('{OP_COMPARE, MAXP, MAXN, 32'd5, MAXN, MAXP, 32'd5, 32'd0});
    send_word('{OP_COMPARE, 32'd10, 32'hffff_fffd, 32'd0, 32'd17, 32'd4, 32'd7, 32'd0});
    send_word('{OP_NORM, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN});
    send_word('{OP_LENGTH, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_word(rand_word());
  endtask

  // stall the receiver for a long stretch while words keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_word(rand_word(), 1);
    join
    drain();
  endtask

  // run without gaps on either side
  task automatic test_streaming();
    idle_out = 0;
    for (int i = 0; i < 100; i++) send_word(rand_word(), 1);
    idle_out = 1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(350);
    write_tolerance(16'd0);
    test_directed();
    test_random(350);
    write_tolerance(16'hffff);
    test_random(300);
    test_backpressure();
    write_tolerance(16'd10);
    test_streaming();
    test_random(350);
    drain();
    $display("sent %0d words, checked %0d results, tolerance 0/7/10/65535, stalls",
             words_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
